// ===== rtl/readout_cell_history_corruption_check_assert.svh =====
// Assertion macros for the block's checker.
`ifndef READOUT_CELL_HISTORY_CORRUPTION_CHECK_ASSERT_SVH
`define READOUT_CELL_HISTORY_CORRUPTION_CHECK_ASSERT_SVH

// Same-cycle implication, off during reset.
`define RCHC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define RCHC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Property that follows a reset cycle.
`define RCHC_ASSERT_AFTER_RST(label, clk, rst, cons, msg) \
  label: assert property (@(posedge clk) (rst) |=> (cons)) else $error(msg);

`endif

// ===== rtl/rchc_pkg.sv =====
// Shared widths, register codes and pipeline structs of the corruption checker.
package rchc_pkg;

  localparam int WORD_W     = 16;
  localparam int MODID_W    = 2;
  localparam int DEPTH_W    = 11;
  localparam int NUM_W      = 32;
  localparam int CNT_W      = 14;
  localparam int DEV_W      = 31;
  localparam int LVL_W      = 30;
  localparam int POS_W      = 15;
  localparam int ROW_W      = 12;
  localparam int STOP_W     = 12;
  localparam int CELL_SUM_W = 13;
  localparam int QUO_W      = 5;
  localparam int MOD_W      = 7;
  localparam int CH_W       = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_W      = 32;
  localparam int RECIP_SH   = 24;
  localparam int NUM_STOPS  = 8;
  localparam int GAIN_COUNT = 2;

  localparam logic [DEPTH_W-1:0] DEPTH_CAP   = 11'd1024;
  localparam logic [DEPTH_W-1:0] DEPTH_RST   = 11'd30;
  localparam logic [NUM_W-1:0]   GATE_RST    = 32'd100;
  localparam logic [NUM_W-1:0]   SIGMA_RST   = 32'd1022209;
  localparam logic [WORD_W-1:0]  LEVEL_RST   = 16'd200;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_READ_DEPTH   = 2'd0,
    REG_TRIGGER_GATE = 2'd1,
    REG_SIGMA_K      = 2'd2,
    REG_LOW_LEVEL    = 2'd3
  } cfg_reg_t;

  // One decoded frame word headed for the history memory
  typedef struct packed {
    logic                  live;
    logic                  sample;
    logic                  start;
    logic                  last;
    logic                  gate_ok;
    logic [WORD_W-1:0]     adc;
    logic [CELL_SUM_W-1:0] cell_sum;
    logic [QUO_W-1:0]      quo;
    logic [MOD_W-1:0]      module_sel;
    logic [CH_W-1:0]       channel;
    logic                  gain;
  } item_t;

  typedef struct packed {
    logic [NUM_W-1:0] event_number;
    logic [NUM_W-1:0] trigger_number;
  } header_t;

  // Frame totals handed to the verdict stages
  typedef struct packed {
    logic                    valid;
    logic signed [DEV_W-1:0] dev;
    logic [CNT_W-1:0]        match_total;
    logic [LVL_W-1:0]        level;
    logic [CNT_W-1:0]        samples;
  } tally_t;

endpackage

// ===== rtl/rchc_frame_if.sv =====
// Frame word channel.
interface rchc_frame_if;
  import rchc_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0]  sample_word;
  logic              start_of_event;
  logic [MODID_W-1:0] module_id;
  modport source (output valid, sample_word, start_of_event, module_id, input ready);
  modport sink (input valid, sample_word, start_of_event, module_id, output ready);
endinterface

// ===== rtl/rchc_result_if.sv =====
// Per-event verdict channel.
interface rchc_result_if;
  import rchc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    corrupted;
  logic                    low_mean;
  logic                    deviation_hit;
  logic [NUM_W-1:0]        event_number;
  logic [NUM_W-1:0]        trigger_number;
  logic [CNT_W-1:0]        matched_count;
  logic signed [DEV_W-1:0] deviation_sum;
  modport source (output valid, corrupted, low_mean, deviation_hit, event_number,
                  trigger_number, matched_count, deviation_sum, input ready);
  modport sink (input valid, corrupted, low_mean, deviation_hit, event_number,
                trigger_number, matched_count, deviation_sum, output ready);
endinterface

// ===== rtl/rchc_frame.sv =====
// Frame parser: word position, header, stop cells and sample decode.
module rchc_frame #(
  parameter int NUM_MODULES  = 4,
  parameter int NUM_CELLS    = 4096,
  parameter int NUM_CHANNELS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [rchc_pkg::WORD_W-1:0]   sample_word,
  input  logic                          start_of_event,
  input  logic [rchc_pkg::MODID_W-1:0]  module_id,
  input  logic [rchc_pkg::DEPTH_W-1:0]  read_depth,
  input  logic [rchc_pkg::NUM_W-1:0]    trigger_gate,
  output logic                          last_pending,
  output rchc_pkg::item_t               item,
  output rchc_pkg::header_t             header
);
  import rchc_pkg::*;

  localparam int RECIP   = (1 << RECIP_SH) / NUM_CELLS;
  localparam int RECIP_W = $clog2(RECIP + 1);
  localparam int PROD_W  = RECIP_SH + QUO_W + 1;

  logic                  in_frame;
  logic [POS_W-1:0]      word_position;
  logic [DEPTH_W-1:0]    frame_depth;
  logic [MOD_W-1:0]      frame_module;
  logic [WORD_W-1:0]     event_hi;
  logic [WORD_W-1:0]     trig_hi;
  logic [NUM_W-1:0]      event_num;
  logic [NUM_W-1:0]      trig_num;
  logic [STOP_W-1:0]     stop_cells [NUM_STOPS];

  logic                  active;
  logic [DEPTH_W-1:0]    cap_depth;
  logic [MOD_W-1:0]      mod_red;
  logic [POS_W-1:0]      pos;
  logic [DEPTH_W-1:0]    depth;
  logic [MOD_W-1:0]      modv;
  logic                  is_last;
  logic [ROW_W-1:0]      row;
  logic [2:0]            rec;
  logic                  odd;
  logic [ROW_W-1:0]      roi;
  logic                  sample;
  logic [CH_W-1:0]       channel;
  logic [CH_W-1:0]       ch_red;
  logic [CELL_SUM_W-1:0] cell_sum;
  logic [PROD_W-1:0]     prod;
  logic [NUM_W-1:0]      hdr_num;

  // Decode the word against the frame it belongs to
  always_comb begin
    cap_depth = (read_depth > DEPTH_CAP) ? DEPTH_CAP : read_depth;
    mod_red = MOD_W'(module_id);
    for (int k = 0; k < 3; k++) begin
      if (int'(mod_red) >= NUM_MODULES) begin
        mod_red = MOD_W'(int'(mod_red) - NUM_MODULES);
      end
    end
    active = accept && (start_of_event || in_frame);
    pos    = start_of_event ? '0 : word_position;
    depth  = start_of_event ? cap_depth : frame_depth;
    modv   = start_of_event ? mod_red : frame_module;
    is_last = (pos == POS_W'({depth, 4'b0000}) + POS_W'(23));
    row = pos[POS_W-1:3];
    rec = pos[2:0];
    odd = (row >= ROW_W'(depth) + ROW_W'(3));
    roi = row - ROW_W'(3) - (odd ? ROW_W'(depth) : '0);
    sample = active && (row >= ROW_W'(3)) && !(odd && rec > 3'd5) &&
             (roi > ROW_W'(1)) && (roi + ROW_W'(1) < ROW_W'(depth));
    channel = {rec[2:1], odd};
    ch_red = (int'(channel) >= NUM_CHANNELS) ? CH_W'(int'(channel) - NUM_CHANNELS)
                                             : channel;
    cell_sum = CELL_SUM_W'(roi) + CELL_SUM_W'(stop_cells[channel]);
    prod = PROD_W'(cell_sum) * PROD_W'(RECIP);
    hdr_num = NUM_W'(sample_word) + {(rec[1] ? trig_hi : event_hi), 16'h0000}
              - NUM_W'(rec[1] ? trig_hi : event_hi);
  end

  assign last_pending = in_frame &&
                        (word_position == POS_W'({frame_depth, 4'b0000}) + POS_W'(23));

  // Advance the frame position
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame      <= 1'b0;
      word_position <= '0;
      frame_depth   <= '0;
      frame_module  <= '0;
      for (int s = 0; s < NUM_STOPS; s++) begin
        stop_cells[s] <= '0;
      end
    end else begin
      if (active) begin
        in_frame      <= !is_last;
        word_position <= is_last ? '0 : pos + POS_W'(1);
        if (start_of_event) begin
          frame_depth  <= cap_depth;
          frame_module <= mod_red;
        end
        if (row == ROW_W'(2)) begin
          stop_cells[rec] <= sample_word[STOP_W-1:0];
        end
      end
    end
  end

  // Hold header numbers and the decoded item
  always_ff @(posedge clk) begin
    if (rst) begin
      item.live <= 1'b0;
    end else begin
      item.live <= active;
    end
    if (active && row == '0) begin
      case (rec)
        3'd0: event_hi <= sample_word;
        3'd1: event_num <= hdr_num;
        3'd2: trig_hi <= sample_word;
        3'd3: trig_num <= hdr_num;
        default: ;
      endcase
    end
    if (active && is_last) begin
      header.event_number   <= event_num;
      header.trigger_number <= trig_num;
    end
    item.sample     <= sample;
    item.start      <= start_of_event;
    item.last       <= is_last;
    item.gate_ok    <= trig_num > trigger_gate;
    item.adc        <= sample_word;
    item.cell_sum   <= cell_sum;
    item.quo        <= prod[RECIP_SH +: QUO_W];
    item.module_sel <= modv;
    item.channel    <= ch_red;
    item.gain       <= rec[0];
  end

endmodule

// ===== rtl/rchc_history.sv =====
// History memory with read-modify-write, clearing pass and frame accumulators.
module rchc_history #(
  parameter int NUM_MODULES   = 4,
  parameter int NUM_CELLS     = 4096,
  parameter int NUM_CHANNELS  = 8,
  parameter int HISTORY_DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  rchc_pkg::item_t  item,
  output logic             clearing,
  output rchc_pkg::tally_t tally
);
  import rchc_pkg::*;

  localparam int ENTRIES = NUM_MODULES * NUM_CHANNELS * NUM_CELLS * GAIN_COUNT;
  localparam int AW      = $clog2(ENTRIES);
  localparam int SLOT_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int HIST_W  = HISTORY_DEPTH * WORD_W;
  localparam int MEM_W   = HIST_W + SLOT_W;
  localparam int DIFF_W  = WORD_W + 1;

  logic [MEM_W-1:0] mem [ENTRIES];
  logic [MEM_W-1:0] rd_data;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [MEM_W-1:0] wr_data;
  logic [AW-1:0]    clear_addr;

  logic [CELL_SUM_W-1:0] rem;
  logic [CELL_SUM_W-1:0] cell_idx;

  logic              p2_live;
  logic              p2_sample;
  logic              p2_start;
  logic              p2_last;
  logic              p2_gate_ok;
  logic [WORD_W-1:0] p2_adc;
  logic [AW-1:0]     p2_addr;

  logic             fw_en;
  logic [AW-1:0]    fw_addr;
  logic [MEM_W-1:0] fw_data;

  logic [MEM_W-1:0]        row_q;
  logic [SLOT_W-1:0]       slot;
  logic [WORD_W-1:0]       hval;
  logic [WORD_W-1:0]       best_h;
  logic [DIFF_W-1:0]       gap;
  logic [DIFF_W-1:0]       best_d;
  logic                    match;
  logic signed [DIFF_W-1:0] diff;
  logic                    upd_en;
  logic [MEM_W-1:0]        upd_data;

  logic signed [DEV_W-1:0] dev;
  logic [CNT_W-1:0]        match_total;
  logic [LVL_W-1:0]        level;
  logic [CNT_W-1:0]        samples;
  logic signed [DEV_W-1:0] dev_next;
  logic [CNT_W-1:0]        match_total_next;
  logic [LVL_W-1:0]        level_next;
  logic [CNT_W-1:0]        samples_next;

  // Reduce the cell and form the entry address
  always_comb begin
    rem  = item.cell_sum - CELL_SUM_W'(int'(item.quo) * NUM_CELLS);
    cell_idx = (rem >= CELL_SUM_W'(NUM_CELLS)) ? rem - CELL_SUM_W'(NUM_CELLS) : rem;
    rd_addr = AW'(((int'(item.module_sel) * NUM_CHANNELS + int'(item.channel)) * NUM_CELLS
                   + int'(cell_idx)) * GAIN_COUNT + int'(item.gain));
  end

  // Memory port: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Sweep every entry to zero after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      clear_addr <= clear_addr + AW'(1);
      if (clear_addr == AW'(ENTRIES - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Carry the item alongside its read
  always_ff @(posedge clk) begin
    if (rst) begin
      p2_live <= 1'b0;
      fw_en   <= 1'b0;
    end else begin
      p2_live <= item.live;
      fw_en   <= upd_en;
    end
    p2_sample  <= item.sample;
    p2_start   <= item.start;
    p2_last    <= item.last;
    p2_gate_ok <= item.gate_ok;
    p2_adc     <= item.adc;
    p2_addr    <= rd_addr;
    fw_addr    <= p2_addr;
    fw_data    <= upd_data;
  end

  // Find the nearest entry and build the updated row
  always_comb begin
    row_q  = (fw_en && fw_addr == p2_addr) ? fw_data : rd_data;
    slot   = row_q[HIST_W +: SLOT_W];
    best_d = '1;
    best_h = '0;
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      hval = row_q[i*WORD_W +: WORD_W];
      gap  = (p2_adc >= hval) ? DIFF_W'(p2_adc - hval) : DIFF_W'(hval - p2_adc);
      if (gap < best_d) begin
        best_d = gap;
        best_h = hval;
      end
    end
    diff  = $signed({1'b0, p2_adc}) - $signed({1'b0, best_h});
    match = p2_sample && (best_h != '0) && p2_gate_ok;

    upd_data = row_q;
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      if (SLOT_W'(i) == slot) begin
        upd_data[i*WORD_W +: WORD_W] = p2_adc;
      end
    end
    upd_data[HIST_W +: SLOT_W] = (int'(slot) == HISTORY_DEPTH - 1) ? '0 : slot + SLOT_W'(1);
    upd_en = p2_live && p2_sample && (p2_adc != '0);

    wr_en   = clearing || upd_en;
    wr_addr = clearing ? clear_addr : p2_addr;
    wr_data = clearing ? '0 : upd_data;

    dev_next         = p2_start ? '0 : dev;
    match_total_next = p2_start ? '0 : match_total;
    level_next       = p2_start ? '0 : level;
    samples_next     = p2_start ? '0 : samples;
    if (match) begin
      dev_next         = dev_next + DEV_W'(diff);
      match_total_next = match_total_next + CNT_W'(1);
    end
    if (p2_sample) begin
      level_next   = level_next + LVL_W'(p2_adc);
      samples_next = samples_next + CNT_W'(1);
    end
  end

  // Advance the frame totals
  always_ff @(posedge clk) begin
    if (rst) begin
      dev         <= '0;
      match_total <= '0;
      level       <= '0;
      samples     <= '0;
      tally.valid <= 1'b0;
    end else begin
      tally.valid <= p2_live && p2_last;
      if (p2_live) begin
        dev         <= dev_next;
        match_total <= match_total_next;
        level       <= level_next;
        samples     <= samples_next;
      end
    end
    tally.dev         <= dev_next;
    tally.match_total <= match_total_next;
    tally.level       <= level_next;
    tally.samples     <= samples_next;
  end

endmodule

// ===== rtl/rchc_judge.sv =====
// Verdict stages: squares, products, comparisons and the result register.
module rchc_judge (
  input  logic                        clk,
  input  logic                        rst,
  input  rchc_pkg::tally_t            tally,
  input  rchc_pkg::header_t           header,
  input  logic [rchc_pkg::NUM_W-1:0]  sigma_k,
  input  logic [rchc_pkg::WORD_W-1:0] low_level,
  rchc_result_if.source               result
);
  import rchc_pkg::*;

  localparam int SQ_W  = 2 * DEV_W;
  localparam int RHS_W = NUM_W + CNT_W;
  localparam int PRD_W = SQ_W + 10;

  logic [DEV_W-1:0]        mag;

  logic                    c_valid;
  logic [SQ_W-1:0]         c_sq;
  logic [RHS_W-1:0]        c_rhs;
  logic [LVL_W-1:0]        c_lreq;
  logic [LVL_W-1:0]        c_level;
  logic [CNT_W-1:0]        c_samples;
  logic [CNT_W-1:0]        c_matches;
  logic signed [DEV_W-1:0] c_dev;

  logic                    d_valid;
  logic [PRD_W-1:0]        d_prod;
  logic [RHS_W-1:0]        d_rhs;
  logic                    d_lowm;
  logic [CNT_W-1:0]        d_matches;
  logic signed [DEV_W-1:0] d_dev;

  logic                    devh;

  assign mag  = tally.dev[DEV_W-1] ? DEV_W'(-tally.dev) : DEV_W'(tally.dev);
  assign devh = (d_matches > CNT_W'(1)) && (d_prod > PRD_W'(d_rhs));

  // Stage valids and result handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid      <= 1'b0;
      d_valid      <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      c_valid <= tally.valid;
      d_valid <= c_valid;
      if (d_valid) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  // Multiply, then scale and compare, then load the result
  always_ff @(posedge clk) begin
    c_sq      <= SQ_W'(mag) * SQ_W'(mag);
    c_rhs     <= RHS_W'(sigma_k) * RHS_W'(tally.match_total);
    c_lreq    <= LVL_W'(low_level) * LVL_W'(tally.samples);
    c_level   <= tally.level;
    c_samples <= tally.samples;
    c_matches <= tally.match_total;
    c_dev     <= tally.dev;

    d_prod    <= {c_sq, 10'b0} - PRD_W'({c_sq, 4'b0}) - PRD_W'({c_sq, 3'b0});
    d_rhs     <= c_rhs;
    d_lowm    <= (c_samples != '0) && (c_level < c_lreq);
    d_matches <= c_matches;
    d_dev     <= c_dev;

    if (d_valid) begin
      result.corrupted      <= d_lowm || devh;
      result.low_mean       <= d_lowm;
      result.deviation_hit  <= devh;
      result.event_number   <= header.event_number;
      result.trigger_number <= header.trigger_number;
      result.matched_count  <= d_matches;
      result.deviation_sum  <= d_dev;
    end
  end

endmodule

// ===== rtl/readout_cell_history_corruption_check.sv =====
// Top level of the event-frame corruption checker with per-cell history.
//
//   channel   dir  handshake     content
//   frame     in   valid/ready   sample_word, start_of_event, module_id
//   result    out  valid/ready   corrupted, low_mean, deviation_hit, numbers, sums
//   cfg       in   cfg_we        cfg_index, cfg_data
//
// One frame word is taken every cycle while ready is high; each word reads the
// history memory, and a nonzero sample writes its entry back (read issued one stage,
// written back the next). The verdict for an event passes the item, history and tally
// registers and two judge stages before it is loaded into the result register.
// After reset a clearing pass zeroes all NUM_MODULES*NUM_CHANNELS*NUM_CELLS*2 history
// entries (262144 at the defaults), one entry per cycle, with ready low.
// Clearing aside, only the last word is held off, while an older verdict waits unread.
module readout_cell_history_corruption_check #(
  parameter int NUM_MODULES   = 4,
  parameter int NUM_CELLS     = 4096,
  parameter int HISTORY_DEPTH = 4,
  parameter int NUM_CHANNELS  = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  rchc_frame_if.sink                     frame,
  rchc_result_if.source                  result,
  input  logic                           cfg_we,
  input  logic [rchc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rchc_pkg::CFG_W-1:0]     cfg_data
);
  import rchc_pkg::*;

  logic [DEPTH_W-1:0] read_depth;
  logic [NUM_W-1:0]   trigger_gate;
  logic [NUM_W-1:0]   sigma_k;
  logic [WORD_W-1:0]  low_level;

  logic    accept;
  logic    last_pending;
  logic    clearing;
  item_t   item;
  header_t header;
  tally_t  tally;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      read_depth   <= DEPTH_RST;
      trigger_gate <= GATE_RST;
      sigma_k      <= SIGMA_RST;
      low_level    <= LEVEL_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_READ_DEPTH:   read_depth   <= cfg_data[DEPTH_W-1:0];
        REG_TRIGGER_GATE: trigger_gate <= cfg_data;
        REG_SIGMA_K:      sigma_k      <= cfg_data;
        REG_LOW_LEVEL:    low_level    <= cfg_data[WORD_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold off every word while clearing, and the closing word while a verdict is still unread
  assign frame.ready = !clearing && !(last_pending && result.valid && !result.ready);
  assign accept      = frame.valid && frame.ready;

  rchc_frame #(
    .NUM_MODULES  (NUM_MODULES),
    .NUM_CELLS    (NUM_CELLS),
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_frame (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .sample_word    (frame.sample_word),
    .start_of_event (frame.start_of_event),
    .module_id      (frame.module_id),
    .read_depth     (read_depth),
    .trigger_gate   (trigger_gate),
    .last_pending   (last_pending),
    .item           (item),
    .header         (header)
  );

  rchc_history #(
    .NUM_MODULES   (NUM_MODULES),
    .NUM_CELLS     (NUM_CELLS),
    .NUM_CHANNELS  (NUM_CHANNELS),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_history (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .clearing (clearing),
    .tally    (tally)
  );

  rchc_judge u_judge (
    .clk       (clk),
    .rst       (rst),
    .tally     (tally),
    .header    (header),
    .sigma_k   (sigma_k),
    .low_level (low_level),
    .result    (result)
  );

endmodule

// ===== rtl/rchc_check.sv =====
// Port-level checker for the corruption checker, bound to the top level.
`include "readout_cell_history_corruption_check_assert.svh"

module rchc_check (
  input logic                        clk,
  input logic                        rst,
  input logic                        frame_ready,
  input logic                        result_valid,
  input logic                        result_ready,
  input logic                        corrupted,
  input logic                        low_mean,
  input logic                        deviation_hit,
  input logic [rchc_pkg::CNT_W-1:0]  matched_count,
  input logic [rchc_pkg::NUM_W-1:0]  event_number
);
  import rchc_pkg::*;

  // History is swept clean before any word is taken
  `RCHC_ASSERT_AFTER_RST(a_clear_after_rst, clk, rst, !frame_ready, "word taken during clearing pass")

  // Verdict is the OR of its two tests
  `RCHC_ASSERT_NOW(a_verdict_or, clk, rst, result_valid, corrupted == (low_mean || deviation_hit), "corrupted disagrees with its tests")

  // Deviation test needs at least two matches
  `RCHC_ASSERT_NOW(a_dev_count, clk, rst, result_valid && deviation_hit, matched_count > CNT_W'(1), "deviation hit with fewer than two matches")

  // Stalled verdict holds
  `RCHC_ASSERT_NEXT(a_stall_hold, clk, rst, result_valid && !result_ready, result_valid && $stable(event_number) && $stable(corrupted), "stalled verdict changed")

endmodule

bind readout_cell_history_corruption_check rchc_check u_check (
  .clk           (clk),
  .rst           (rst),
  .frame_ready   (frame.ready),
  .result_valid  (result.valid),
  .result_ready  (result.ready),
  .corrupted     (result.corrupted),
  .low_mean      (result.low_mean),
  .deviation_hit (result.deviation_hit),
  .matched_count (result.matched_count),
  .event_number  (result.event_number)
);

// ===== tb/sv/testbench.sv =====
// Self-checking bench for the event-frame corruption checker with per-cell history.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rchc_pkg::*;

  typedef struct packed {
    logic                    corrupted;
    logic                    low_mean;
    logic                    deviation_hit;
    logic [NUM_W-1:0]        event_number;
    logic [NUM_W-1:0]        trigger_number;
    logic [CNT_W-1:0]        matched_count;
    logic signed [DEV_W-1:0] deviation_sum;
  } verdict_t;

  typedef struct packed {
    logic     fixed;
    verdict_t want;
  } typed_verdict_t;

  typedef enum {FILL_ZERO, FILL_MAX, FILL_ONE, FILL_RAND, FILL_NEAR} fill_t;

  typedef struct {
    int               depth;
    logic [NUM_W-1:0] gate;
    logic [NUM_W-1:0] sigma;
    logic [15:0]      low;
    logic [1:0]       mid;
    logic [15:0]      ehi, elo, thi, tlo, stop;
    fill_t            fill;
    int               base;
    int               noise;
    bit               abort;
    bit               fixed;
    verdict_t         want;
  } frame_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  rchc_frame_if  frame_ch();
  rchc_result_if verdict_ch();

  readout_cell_history_corruption_check u_top (
    .clk      (clk),
    .rst      (rst),
    .frame    (frame_ch),
    .result   (verdict_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Predictor state
  logic [3:0][15:0] hist_mem [int];
  logic [1:0]       slot_mem [int];
  logic [11:0]      stops [8];
  logic [3:0][15:0] hdr;
  int               pos;
  bit               in_frame;
  int               fdepth;
  int               fmod;
  int               dev_acc;
  int unsigned      match_cnt;
  logic [31:0]      lvl_acc;
  int unsigned      samp_cnt;
  logic [DEPTH_W-1:0] m_depth = DEPTH_RST;
  logic [NUM_W-1:0]   m_gate  = GATE_RST;
  logic [NUM_W-1:0]   m_sigma = SIGMA_RST;
  logic [15:0]        m_low   = LEVEL_RST;

  verdict_t       pending_verdicts [$];
  typed_verdict_t typed_q [$];
  int             errors = 0;
  int             verdicts_seen = 0;
  int             words_sent = 0;
  bit             idle_on = 1;
  int             stall_left = 0;
  int             mod_base [4];
  logic [15:0]    mod_stop [4];
  frame_row_t     plan [12];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [31:0] hdr_num(int hi);
    return 32'(hdr[hi+1]) + 32'hffff * 32'(hdr[hi]);
  endfunction

  function automatic verdict_t verdict(bit c, bit l, bit d, logic [31:0] e, logic [31:0] t,
                                       logic [13:0] m, logic signed [30:0] s);
    verdict_t v;
    v = '{c, l, d, e, t, m, s};
    return v;
  endfunction

  // Advance the frame model by one accepted word
  task automatic track_word(input logic [15:0] w, input logic sof, input logic [1:0] mid);
    int row, rec, roi, ch, idx, best, d, bestd;
    bit odd;
    logic [3:0][15:0] h;
    logic [1:0] s;
    logic [63:0] mag, sq;
    bit lowm, devh;
    verdict_t v;
    typed_verdict_t tv;
    if (sof) begin
      in_frame = 1;
      pos = 0;
      hdr = '0;
      dev_acc = 0;
      match_cnt = 0;
      lvl_acc = '0;
      samp_cnt = 0;
      fdepth = (m_depth > DEPTH_CAP) ? DEPTH_CAP : m_depth;
      fmod = mid;
    end else if (!in_frame) begin
      return;
    end
    row = pos >> 3;
    rec = pos & 7;
    if (row == 0) begin
      if (rec < 4) hdr[rec] = w;
    end else if (row == 2) begin
      stops[rec] = w[11:0];
    end else if (row >= 3) begin
      odd = (row >= 3 + fdepth);
      roi = row - 3 - (odd ? fdepth : 0);
      if (!(odd && rec > 5) && roi > 1 && roi + 1 < fdepth) begin
        ch = (rec & 6) + odd;
        idx = ((fmod * 8 + ch) * 4096 + (roi + stops[ch]) % 4096) * 2 + (rec & 1);
        h = hist_mem.exists(idx) ? hist_mem[idx] : '0;
        s = slot_mem.exists(idx) ? slot_mem[idx] : '0;
        best = 0;
        bestd = 9999999;
        // First entry nearest to the sample wins
        for (int i = 0; i < 4; i++) begin
          d = int'(w) - int'(h[i]);
          if (d < 0) d = -d;
          if (d < bestd) begin
            bestd = d;
            best = i;
          end
        end
        if (h[best] != 0 && hdr_num(2) > m_gate) begin
          dev_acc += int'(w) - int'(h[best]);
          match_cnt++;
        end
        lvl_acc += 32'(w);
        samp_cnt++;
        // Overwrite round robin on a positive sample
        if (w != 0) begin
          h[s] = w;
          hist_mem[idx] = h;
          slot_mem[idx] = s + 2'd1;
        end
      end
    end
    pos++;
    if (pos < (3 + 2 * fdepth) * 8) return;
    in_frame = 0;
    lowm = samp_cnt > 0 && 64'(lvl_acc) < 64'(m_low) * 64'(samp_cnt);
    mag = dev_acc < 0 ? 64'(-longint'(dev_acc)) : 64'(dev_acc);
    sq = mag * mag;
    devh = 0;
    if (match_cnt > 1)
      devh = (sq > (64'd1 << 46)) || (sq * 64'd1000 > 64'(m_sigma) * 64'(match_cnt));
    v = verdict(lowm || devh, lowm, devh, hdr_num(0), hdr_num(2), match_cnt[13:0],
                dev_acc[30:0]);
    tv = '0;
    if (typed_q.size() > 0) tv = typed_q.pop_front();
    pending_verdicts.push_back(tv.fixed ? tv.want : v);
  endtask

  task automatic report(input string name, input logic [63:0] e, input logic [63:0] a);
    if (e !== a) begin
      $display("%0t %s expected %h actual %h", $time, name, e, a);
      errors++;
    end
  endtask

  // Sample both channels and the register port
  always @(posedge clk) begin
    verdict_t e;
    if (!rst) begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_READ_DEPTH:   m_depth = cfg_data[DEPTH_W-1:0];
          REG_TRIGGER_GATE: m_gate = cfg_data;
          REG_SIGMA_K:      m_sigma = cfg_data;
          REG_LOW_LEVEL:    m_low = cfg_data[15:0];
          default: ;
        endcase
      end
      if (frame_ch.valid && frame_ch.ready)
        track_word(frame_ch.sample_word, frame_ch.start_of_event, frame_ch.module_id);
      if (verdict_ch.valid && verdict_ch.ready) begin
        verdicts_seen++;
        if (pending_verdicts.size() == 0) begin
          $display("%0t verdict with none expected: actual %h", $time,
                   {verdict_ch.corrupted, verdict_ch.low_mean, verdict_ch.deviation_hit,
                    verdict_ch.event_number, verdict_ch.trigger_number,
                    verdict_ch.matched_count, verdict_ch.deviation_sum});
          errors++;
        end else begin
          e = pending_verdicts.pop_front();
          report("corrupted", e.corrupted, verdict_ch.corrupted);
          report("low_mean", e.low_mean, verdict_ch.low_mean);
          report("deviation_hit", e.deviation_hit, verdict_ch.deviation_hit);
          report("event_number", e.event_number, verdict_ch.event_number);
          report("trigger_number", e.trigger_number, verdict_ch.trigger_number);
          report("matched_count", e.matched_count, verdict_ch.matched_count);
          report("deviation_sum", e.deviation_sum, verdict_ch.deviation_sum);
        end
      end
    end
  end

  // Stall the verdict sink in random bursts
  always @(negedge clk) begin
    if (!idle_on) begin
      verdict_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      verdict_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 18) - 1;
      verdict_ch.ready <= 1'b0;
    end else begin
      verdict_ch.ready <= 1'b1;
    end
  end

  // Hand one word over; returns at the falling edge after it was taken
  task automatic drive_word(input logic [15:0] w, input logic sof, input logic [1:0] mid);
    if (idle_on && $urandom_range(0, 9) == 0) begin
      frame_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    frame_ch.valid <= 1'b1;
    frame_ch.sample_word <= w;
    frame_ch.start_of_event <= sof;
    frame_ch.module_id <= mid;
    @(posedge clk);
    while (!frame_ch.ready) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  // Drain, let the pipeline settle, then write all four registers
  task automatic program_regs(input int depth, input logic [31:0] gate,
                              input logic [31:0] sigma, input logic [15:0] low);
    frame_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_READ_DEPTH;
    cfg_data <= 32'(depth);
    @(negedge clk);
    cfg_index <= REG_TRIGGER_GATE;
    cfg_data <= gate;
    @(negedge clk);
    cfg_index <= REG_SIGMA_K;
    cfg_data <= sigma;
    @(negedge clk);
    cfg_index <= REG_LOW_LEVEL;
    cfg_data <= 32'(low);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Send stray words, an optional abandoned frame, then one whole frame
  task automatic send_frame(input int depth, input logic [1:0] mid,
                            input logic [15:0] ehi, input logic [15:0] elo,
                            input logic [15:0] thi, input logic [15:0] tlo,
                            input logic [15:0] stop, input fill_t fill, input int base,
                            input int noise, input bit abort, input bit fixed,
                            input verdict_t want);
    int eff, len, n, row, rec, v;
    logic [15:0] w;
    typed_verdict_t tv;
    eff = depth > 1024 ? 1024 : depth;
    len = (3 + 2 * eff) * 8;
    repeat (noise) drive_word(16'($urandom), 1'b0, 2'($urandom));
    for (int part = abort ? 0 : 1; part < 2; part++) begin
      n = part ? len : $urandom_range(1, len - 1);
      if (part) begin
        tv = '{fixed, want};
        typed_q.push_back(tv);
      end
      for (int p = 0; p < n; p++) begin
        row = p / 8;
        rec = p % 8;
        w = 16'($urandom);
        if (row == 0) begin
          case (rec)
            0: w = ehi;
            1: w = elo;
            2: w = thi;
            3: w = tlo;
            default: ;
          endcase
        end else if (row == 2) begin
          w = stop + 16'(rec * 37);
        end else if (row >= 3 && !(row >= 3 + eff && rec > 5)) begin
          case (fill)
            FILL_ZERO: w = 16'h0000;
            FILL_MAX:  w = 16'hffff;
            FILL_ONE:  w = 16'h0001;
            FILL_RAND: if ($urandom_range(0, 15) == 0) w = 16'h0000;
            default: begin
              v = base + $urandom_range(0, 20) - 10;
              if (v < 1) v = 1;
              if (v > 65535) v = 65535;
              w = ($urandom_range(0, 31) == 0) ? 16'h0000 : 16'(v);
            end
          endcase
        end
        drive_word(w, p == 0, p == 0 ? mid : 2'($urandom));
      end
    end
  endtask

  initial begin
    int depth, r, ncnt;
    logic [31:0] gate, sigma;
    logic [15:0] low, thi, tlo;
    logic [1:0] mid;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_READ_DEPTH;
    cfg_data = '0;
    frame_ch.valid = 1'b0;
    frame_ch.sample_word = '0;
    frame_ch.start_of_event = 1'b0;
    frame_ch.module_id = '0;
    verdict_ch.ready = 1'b0;
    for (int i = 0; i < 4; i++) begin
      mod_base[i] = $urandom_range(300, 8000);
      mod_stop[i] = 16'($urandom);
    end

    // Directed frames: empty history, zero and full samples, depth extremes
    plan[0]  = '{30, GATE_RST, SIGMA_RST, LEVEL_RST, 2'd0, 16'hffff, 16'hffff, 16'h0, 16'h5,
                 16'h0, FILL_MAX, 0, 3, 0, 1, verdict(0, 0, 0, 32'hffff0000, 32'd5, 0, 0)};
    plan[1]  = '{30, GATE_RST, SIGMA_RST, LEVEL_RST, 2'd0, 16'h0, 16'h0, 16'h0, 16'h5,
                 16'h0, FILL_ZERO, 0, 0, 0, 1, verdict(1, 1, 0, 32'd0, 32'd5, 0, 0)};
    // Nearest entry is zero although another entry is positive
    plan[2]  = '{30, 32'd0, SIGMA_RST, LEVEL_RST, 2'd0, 16'h0, 16'h1, 16'h0, 16'h1,
                 16'h0, FILL_ONE, 0, 0, 0, 1, verdict(1, 1, 0, 32'd1, 32'd1, 0, 0)};
    plan[3]  = '{30, 32'd0, SIGMA_RST, LEVEL_RST, 2'd0, 16'd1234, 16'd5678, 16'h0, 16'd500,
                 16'h0, FILL_NEAR, 3000, 0, 1, 0, '0};
    plan[4]  = '{0, 32'd0, SIGMA_RST, LEVEL_RST, 2'd1, 16'h1, 16'h2, 16'h3, 16'h4,
                 16'h0, FILL_RAND, 0, 0, 0, 0, '0};
    plan[5]  = '{1, 32'd0, SIGMA_RST, LEVEL_RST, 2'd2, 16'h8000, 16'h0, 16'h0, 16'h8000,
                 16'h0, FILL_RAND, 0, 0, 0, 0, '0};
    plan[6]  = '{3, 32'd0, SIGMA_RST, LEVEL_RST, 2'd3, 16'h7fff, 16'h1, 16'h0, 16'hffff,
                 16'hffff, FILL_RAND, 0, 0, 0, 0, '0};
    plan[7]  = '{4, 32'd0, 32'd0, 16'hffff, 2'd3, 16'h0, 16'h9, 16'h0, 16'h9,
                 16'hffff, FILL_NEAR, 10, 0, 0, 0, '0};
    plan[8]  = '{4, 32'd0, 32'd0, 16'hffff, 2'd3, 16'h0, 16'ha, 16'h0, 16'ha,
                 16'hffff, FILL_NEAR, 40000, 0, 0, 0, '0};
    plan[9]  = '{12, 32'hffffffff, 32'hffffffff, 16'h0, 2'd0, 16'hffff, 16'h0,
                 16'hffff, 16'hffff, 16'h0a5a, FILL_RAND, 0, 0, 0, 0, '0};
    plan[10] = '{2047, 32'd0, 32'hffffffff, 16'hffff, 2'd1, 16'h1, 16'h1, 16'h0, 16'h7,
                 16'h0fff, FILL_NEAR, 20000, 0, 0, 0, '0};
    plan[11] = '{5, GATE_RST, SIGMA_RST, LEVEL_RST, 2'd2, 16'h2, 16'h3, 16'h0, 16'd200,
                 16'hf123, FILL_NEAR, 500, 2, 1, 0, '0};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) begin
      program_regs(plan[i].depth, plan[i].gate, plan[i].sigma, plan[i].low);
      send_frame(plan[i].depth, plan[i].mid, plan[i].ehi, plan[i].elo, plan[i].thi,
                 plan[i].tlo, plan[i].stop, plan[i].fill, plan[i].base, plan[i].noise,
                 plan[i].abort, plan[i].fixed, plan[i].want);
    end

    // Random phases: mostly well-formed short frames that revisit the same cells
    while (verdicts_seen < 60 || words_sent < 1850) begin
      if (words_sent > 1650 && verdicts_seen >= 50) idle_on = 0;
      else idle_on = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 19);
      if (r == 0) depth = $urandom_range(0, 3);
      else if (r == 1) depth = $urandom_range(10, 40);
      else depth = $urandom_range(4, 9);
      case ($urandom_range(0, 3))
        0: gate = 32'd0;
        1: gate = GATE_RST;
        2: gate = $urandom;
        default: gate = 32'hffffffff;
      endcase
      case ($urandom_range(0, 3))
        0: sigma = 32'd0;
        1: sigma = SIGMA_RST;
        2: sigma = $urandom;
        default: sigma = 32'hffffffff;
      endcase
      case ($urandom_range(0, 3))
        0: low = 16'd0;
        1: low = LEVEL_RST;
        2: low = 16'($urandom);
        default: low = 16'hffff;
      endcase
      program_regs(depth, gate, sigma, low);
      repeat ($urandom_range(3, 6)) begin
        mid = 2'($urandom);
        if ($urandom_range(0, 7) == 0) mod_stop[mid] = 16'($urandom);
        mod_base[mid] = mod_base[mid] + $urandom_range(0, 200) - 100;
        if ($urandom_range(0, 5) == 0) mod_base[mid] = $urandom_range(50, 60000);
        if ($urandom_range(0, 3) == 0) begin
          thi = 16'($urandom);
          tlo = 16'($urandom);
        end else begin
          thi = 16'h0;
          tlo = 16'($urandom_range(0, 300));
        end
        ncnt = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0;
        send_frame(depth, mid, 16'($urandom), 16'($urandom), thi, tlo, mod_stop[mid],
                   ($urandom_range(0, 4) == 0) ? FILL_RAND : FILL_NEAR, mod_base[mid],
                   ncnt, $urandom_range(0, 9) == 0, 1'b0, '0);
      end
    end

    // Wait for the last verdicts, then settle
    frame_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/rchc_pkg.sv
rtl/rchc_frame_if.sv
rtl/rchc_result_if.sv
rtl/rchc_frame.sv
rtl/rchc_history.sv
rtl/rchc_judge.sv
rtl/readout_cell_history_corruption_check.sv
rtl/rchc_check.sv
tb/sv/testbench.sv
